### rtl/core/window_2x2_avg_max_filter_unit_macros.svh
// Assertion macros used by the checker file of the 2x2 window filter.
// Needs nothing else; every macro expands to one labeled concurrent assertion.
`ifndef WINDOW_2X2_AVG_MAX_FILTER_UNIT_MACROS_SVH
`define WINDOW_2X2_AVG_MAX_FILTER_UNIT_MACROS_SVH

// Same-cycle implication, checked at every rising clock edge outside reset.
`define WAMF_ASSERT_NOW(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, checked at every rising clock edge outside reset.
`define WAMF_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

### rtl/core/wamf_pkg.sv
// Package of the 2x2 window filter: widths, register indexes, result codes,
// the job record passed from front to back, and small arithmetic helpers.
// Depends on nothing.
`default_nettype none

package wamf_pkg;

   // Field widths fixed by the interface.
   localparam int SAMPLE_W  = 16;
   localparam int VALUE_W   = 18;
   localparam int IDX_W     = 10;
   localparam int CFG_W     = 11;
   localparam int CSR_IDX_W = 2;

   // Default frame limits.
   localparam int MAX_COLS_DEF = 1024;
   localparam int MAX_ROWS_DEF = 1024;

   // Job queue between front and back.
   localparam int QDEPTH = 4;
   localparam int QPTR_W = $clog2(QDEPTH);
   localparam int LVL_W  = $clog2(QDEPTH + 1);

   // Configuration register indexes.
   localparam logic [CSR_IDX_W-1:0] CSR_OP_MODE    = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_FRAME_ROWS = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_FRAME_COLS = 2'd2;

   // One-hot result codes, in raster order of their positions.
   localparam int NRES = 4;
   localparam logic [NRES-1:0] RES_DIAG   = 4'b0001;  // (r-1, c-1), full window
   localparam logic [NRES-1:0] RES_UPPER  = 4'b0010;  // (r-1, c), vertical pair
   localparam logic [NRES-1:0] RES_LEFT   = 4'b0100;  // (r, c-1), horizontal pair
   localparam logic [NRES-1:0] RES_CORNER = 4'b1000;  // (r, c), bottom-right

   typedef logic signed [SAMPLE_W-1:0] sample_type;
   typedef logic signed [VALUE_W-1:0]  value_type;
   typedef logic [IDX_W-1:0]           idx_type;

   // Everything the back part needs to produce the results of one request.
   typedef struct packed {
      sample_type          cur;
      sample_type          upper;
      sample_type          left;
      sample_type          upleft;
      idx_type             row;
      idx_type             col;
      logic [NRES-1:0]     mask;
      logic                max_mode;
   } job_type;

   // Sign extension of a sample to the result width.
   function automatic value_type sx(sample_type v);
      return {{(VALUE_W - SAMPLE_W){v[SAMPLE_W-1]}}, v};
   endfunction

   function automatic sample_type max2(sample_type a, sample_type b);
      return (a > b) ? a : b;
   endfunction

   // A sample times four.
   function automatic value_type times4(sample_type v);
      return {v, 2'b00};
   endfunction

endpackage

`default_nettype wire

### rtl/core/wamf_ram.sv
// Generic single-write, single-read RAM with registered, read-first output.
// Depends on nothing.
`default_nettype none

module wamf_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 1024
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // A read at the address being written returns the old contents.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

### rtl/core/wamf_front.sv
// Front part of the 2x2 window filter: configuration registers, raster
// position, line store, and classification of each request into a job.
// Depends on wamf_pkg and wamf_ram.
`default_nettype none

module wamf_front #(
   parameter int MAX_COLS = wamf_pkg::MAX_COLS_DEF,
   parameter int MAX_ROWS = wamf_pkg::MAX_ROWS_DEF
) (
   input  wire logic                               clock,
   input  wire logic                               reset,
   // Request channel.
   input  wire logic                               req_valid,
   input  wire wamf_pkg::sample_type               req_sample,
   output logic                                    req_stall,
   // Configuration writes.
   input  wire logic                               csr_valid,
   input  wire logic [wamf_pkg::CSR_IDX_W-1:0]     csr_index,
   input  wire logic [wamf_pkg::CFG_W-1:0]         csr_data,
   // Job queue side.
   input  wire logic [wamf_pkg::LVL_W-1:0]         queue_level,
   output logic                                    push_valid,
   output wamf_pkg::job_type                       push_job
);

   localparam int COL_W = $clog2(MAX_COLS);
   localparam int ROW_W = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
   localparam int IdxW  = wamf_pkg::IDX_W;
   localparam int LvlW  = wamf_pkg::LVL_W;

   // Configuration and position state.
   logic                 mode_ff, mode_in;
   logic [COL_W-1:0]     last_col_ff, last_col_in;
   logic [ROW_W-1:0]     last_row_ff, last_row_in;
   logic [COL_W-1:0]     col_ff, col_in;
   logic [ROW_W-1:0]     row_ff, row_in;

   // Stage after acceptance, waiting for the line store read.
   logic                         s1_valid_ff;
   wamf_pkg::sample_type         s1_cur_ff;
   wamf_pkg::idx_type            s1_row_ff;
   wamf_pkg::idx_type            s1_col_ff;
   logic [wamf_pkg::NRES-1:0]    s1_mask_ff, s1_mask_in;
   logic                         s1_mode_ff;

   // Neighbor samples of the previous request.
   wamf_pkg::sample_type         left_ff;
   wamf_pkg::sample_type         upleft_ff;
   wamf_pkg::sample_type         upper;

   logic                         accept;
   logic [LvlW:0]                credit_used;
   logic [31:0]                  rows_eff;
   logic [31:0]                  cols_eff;
   logic [31:0]                  cfg_value;
   logic                         first_row, first_col, end_row, end_col;

   // Stall once every queue slot is spoken for, counting the request in flight.
   assign credit_used = {1'b0, queue_level} + (LvlW + 1)'(s1_valid_ff);
   assign req_stall   = (credit_used >= (LvlW + 1)'(wamf_pkg::QDEPTH));
   assign accept      = req_valid && !req_stall;

   // Frame sizes: zero acts as one, oversize values clamp to the maximum.
   assign cfg_value = 32'(csr_data);
   assign rows_eff  = (cfg_value == 32'd0) ? 32'd1 :
                      (cfg_value > 32'(MAX_ROWS)) ? 32'(MAX_ROWS) : cfg_value;
   assign cols_eff  = (cfg_value == 32'd0) ? 32'd1 :
                      (cfg_value > 32'(MAX_COLS)) ? 32'(MAX_COLS) : cfg_value;

   // Position classification of the accepted sample.
   assign first_row = (row_ff == '0);
   assign first_col = (col_ff == '0);
   assign end_row   = (row_ff == last_row_ff);
   assign end_col   = (col_ff == last_col_ff);

   always_comb begin
      s1_mask_in = '0;
      if (!first_row && !first_col) begin
         s1_mask_in = s1_mask_in | wamf_pkg::RES_DIAG;
      end
      if (!first_row && end_col) begin
         s1_mask_in = s1_mask_in | wamf_pkg::RES_UPPER;
      end
      if (end_row && !first_col) begin
         s1_mask_in = s1_mask_in | wamf_pkg::RES_LEFT;
      end
      if (end_row && end_col) begin
         s1_mask_in = s1_mask_in | wamf_pkg::RES_CORNER;
      end
   end

   // Register writes, raster position advance and frame restart.
   always_comb begin
      mode_in     = mode_ff;
      last_row_in = last_row_ff;
      last_col_in = last_col_ff;
      col_in      = col_ff;
      row_in      = row_ff;
      if (csr_valid) begin
         case (csr_index)
            wamf_pkg::CSR_OP_MODE: begin
               mode_in = csr_data[0];
            end
            wamf_pkg::CSR_FRAME_ROWS: begin
               last_row_in = ROW_W'(rows_eff - 32'd1);
               col_in      = '0;
               row_in      = '0;
            end
            wamf_pkg::CSR_FRAME_COLS: begin
               last_col_in = COL_W'(cols_eff - 32'd1);
               col_in      = '0;
               row_in      = '0;
            end
            default: begin
            end
         endcase
      end else if (accept) begin
         if (end_col) begin
            col_in = '0;
            row_in = end_row ? '0 : row_ff + ROW_W'(1);
         end else begin
            col_in = col_ff + COL_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff     <= 1'b0;
         last_row_ff <= '0;
         last_col_ff <= '0;
         col_ff      <= '0;
         row_ff      <= '0;
         s1_valid_ff <= 1'b0;
         left_ff     <= '0;
         upleft_ff   <= '0;
      end else begin
         mode_ff     <= mode_in;
         last_row_ff <= last_row_in;
         last_col_ff <= last_col_in;
         col_ff      <= col_in;
         row_ff      <= row_in;
         s1_valid_ff <= accept;
         if (s1_valid_ff) begin
            left_ff   <= s1_cur_ff;
            upleft_ff <= upper;
         end
      end
   end

   // Payload of the stage after acceptance.
   always_ff @(posedge clock) begin
      if (accept) begin
         s1_cur_ff  <= req_sample;
         s1_row_ff  <= IdxW'(row_ff);
         s1_col_ff  <= IdxW'(col_ff);
         s1_mask_ff <= s1_mask_in;
         s1_mode_ff <= mode_ff;
      end
   end

   // Line store holding the previous row; read and written at the same column.
   wamf_ram #(
      .WIDTH (wamf_pkg::SAMPLE_W),
      .DEPTH (MAX_COLS)
   ) u_line_store (
      .clock   (clock),
      .wr_en   (accept),
      .wr_addr (col_ff),
      .wr_data (req_sample),
      .rd_en   (accept),
      .rd_addr (col_ff),
      .rd_data (upper)
   );

   // Only requests that produce results become jobs.
   assign push_valid        = s1_valid_ff && (s1_mask_ff != '0);
   assign push_job.cur      = s1_cur_ff;
   assign push_job.upper    = upper;
   assign push_job.left     = left_ff;
   assign push_job.upleft   = upleft_ff;
   assign push_job.row      = s1_row_ff;
   assign push_job.col      = s1_col_ff;
   assign push_job.mask     = s1_mask_ff;
   assign push_job.max_mode = s1_mode_ff;

endmodule

`default_nettype wire

### rtl/core/wamf_queue.sv
// Short job queue that decouples the front part from the back part.
// Depends on wamf_pkg.
`default_nettype none

module wamf_queue (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          push_valid,
   input  wire wamf_pkg::job_type             push_job,
   input  wire logic                          pop,
   output logic                               head_valid,
   output wamf_pkg::job_type                  head_job,
   output logic [wamf_pkg::LVL_W-1:0]         level
);

   localparam int PtrW = wamf_pkg::QPTR_W;
   localparam int LvlW = wamf_pkg::LVL_W;

   wamf_pkg::job_type     entry_ff [wamf_pkg::QDEPTH];
   logic [PtrW-1:0]       wr_ptr_ff, wr_ptr_in;
   logic [PtrW-1:0]       rd_ptr_ff, rd_ptr_in;
   logic [LvlW-1:0]       level_ff, level_in;
   logic                  do_pop;

   // The front only pushes when it holds a credit, so a push never overflows.
   assign do_pop = pop && (level_ff != '0);

   // Pointers wrap at the queue depth.
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      level_in  = level_ff;
      if (push_valid) begin
         wr_ptr_in = (wr_ptr_ff == PtrW'(wamf_pkg::QDEPTH - 1)) ? '0 : wr_ptr_ff + PtrW'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PtrW'(wamf_pkg::QDEPTH - 1)) ? '0 : rd_ptr_ff + PtrW'(1);
      end
      if (push_valid && !do_pop) begin
         level_in = level_ff + LvlW'(1);
      end else if (!push_valid && do_pop) begin
         level_in = level_ff - LvlW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         level_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         level_ff  <= level_in;
      end
   end

   // Job storage.
   always_ff @(posedge clock) begin
      if (push_valid) begin
         entry_ff[wr_ptr_ff] <= push_job;
      end
   end

   assign head_valid = (level_ff != '0);
   assign head_job   = entry_ff[rd_ptr_ff];
   assign level      = level_ff;

endmodule

`default_nettype wire

### rtl/core/wamf_back.sv
// Back part of the 2x2 window filter: expands each job into its results,
// one per cycle while the response is not stalled, and holds the response in an output register.
// Depends on wamf_pkg.
`default_nettype none

module wamf_back (
   input  wire logic                  clock,
   input  wire logic                  reset,
   // Job queue side.
   input  wire logic                  head_valid,
   input  wire wamf_pkg::job_type     head_job,
   output logic                       pop,
   // Response channel.
   output logic                       rsp_valid,
   input  wire logic                  rsp_stall,
   output wamf_pkg::idx_type          rsp_out_row,
   output wamf_pkg::idx_type          rsp_out_col,
   output wamf_pkg::value_type        rsp_value_q2,
   output logic                       rsp_run_last,
   output logic                       rsp_frame_end
);

   localparam int NRes = wamf_pkg::NRES;
   localparam int IdxW = wamf_pkg::IDX_W;

   logic [NRes-1:0]          done_ff, done_in;
   logic [NRes-1:0]          pending, sel, rest;
   logic                     emit;

   logic                     rsp_valid_ff, rsp_valid_in;
   wamf_pkg::idx_type        row_ff, row_in;
   wamf_pkg::idx_type        col_ff, col_in;
   wamf_pkg::value_type      value_ff, value_in;
   logic                     run_last_ff;
   logic                     frame_end_ff;

   wamf_pkg::value_type      sum4, sum_up, sum_left;
   wamf_pkg::sample_type     max_all, max_up, max_left;
   wamf_pkg::idx_type        row_prev, col_prev;

   // Next result of the head job: lowest code not yet delivered.
   assign pending = head_job.mask & ~done_ff;
   assign sel     = pending & (~pending + NRes'(1));
   assign rest    = pending & ~sel;
   assign emit    = head_valid && (!rsp_valid_ff || !rsp_stall);
   assign pop     = emit && (rest == '0);

   always_comb begin
      done_in = done_ff;
      if (emit) begin
         done_in = (rest == '0) ? '0 : (done_ff | sel);
      end
   end

   // Window arithmetic in quarter units.
   assign sum4     = wamf_pkg::sx(head_job.upleft) + wamf_pkg::sx(head_job.upper)
                   + wamf_pkg::sx(head_job.left) + wamf_pkg::sx(head_job.cur);
   assign sum_up   = (wamf_pkg::sx(head_job.upper) + wamf_pkg::sx(head_job.cur)) <<< 1;
   assign sum_left = (wamf_pkg::sx(head_job.left) + wamf_pkg::sx(head_job.cur)) <<< 1;
   assign max_up   = wamf_pkg::max2(head_job.upper, head_job.cur);
   assign max_left = wamf_pkg::max2(head_job.left, head_job.cur);
   assign max_all  = wamf_pkg::max2(wamf_pkg::max2(head_job.upleft, head_job.upper),
                                    max_left);
   assign row_prev = head_job.row - IdxW'(1);
   assign col_prev = head_job.col - IdxW'(1);

   // Result selection.
   always_comb begin
      row_in   = head_job.row;
      col_in   = head_job.col;
      value_in = wamf_pkg::times4(head_job.cur);
      case (sel)
         wamf_pkg::RES_DIAG: begin
            row_in   = row_prev;
            col_in   = col_prev;
            value_in = head_job.max_mode ? wamf_pkg::times4(max_all) : sum4;
         end
         wamf_pkg::RES_UPPER: begin
            row_in   = row_prev;
            value_in = head_job.max_mode ? wamf_pkg::times4(max_up) : sum_up;
         end
         wamf_pkg::RES_LEFT: begin
            col_in   = col_prev;
            value_in = head_job.max_mode ? wamf_pkg::times4(max_left) : sum_left;
         end
         wamf_pkg::RES_CORNER: begin
            value_in = wamf_pkg::times4(head_job.cur);
         end
         default: begin
         end
      endcase
   end

   // Output register: loads when empty or when its response is taken.
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (emit) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         done_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         done_ff      <= done_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (emit) begin
         row_ff       <= row_in;
         col_ff       <= col_in;
         value_ff     <= value_in;
         run_last_ff  <= (rest == '0);
         frame_end_ff <= (sel == wamf_pkg::RES_CORNER);
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_out_row   = row_ff;
   assign rsp_out_col   = col_ff;
   assign rsp_value_q2  = value_ff;
   assign rsp_run_last  = run_last_ff;
   assign rsp_frame_end = frame_end_ff;

endmodule

`default_nettype wire

### rtl/core/window_2x2_avg_max_filter_unit.sv
// Top level of the 2x2 forward window filter (average or maximum).
// Depends on wamf_pkg, wamf_front, wamf_queue and wamf_back.
//
//   channel   direction  handshake            payload
//   req       in         req_valid/req_stall  req_sample
//   rsp       out        rsp_valid/rsp_stall  rsp_out_row, rsp_out_col, rsp_value_q2,
//                                             rsp_run_last, rsp_frame_end
//   csr       in         csr_valid/csr_ready  csr_index, csr_data
//
// One request per cycle is taken while req_stall is low and each produces at most one
// response; a request at a frame edge produces up to four, and the single response
// register issues them one per cycle while rsp_stall is low.
// The first response of a request passes the stage after acceptance, the job queue and the output register.
// Reset is synchronous; it empties the job queue and output register and starts a frame.
// Response stalls fill the four-entry job queue; req_stall rises once its entries are all used or claimed.
`default_nettype none

module window_2x2_avg_max_filter_unit #(
   parameter int MAX_COLS = wamf_pkg::MAX_COLS_DEF,
   parameter int MAX_ROWS = wamf_pkg::MAX_ROWS_DEF
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   // Request channel.
   input  wire logic                            req_valid,
   output logic                                 req_stall,
   input  wire wamf_pkg::sample_type            req_sample,
   // Response channel.
   output logic                                 rsp_valid,
   input  wire logic                            rsp_stall,
   output wamf_pkg::idx_type                    rsp_out_row,
   output wamf_pkg::idx_type                    rsp_out_col,
   output wamf_pkg::value_type                  rsp_value_q2,
   output logic                                 rsp_run_last,
   output logic                                 rsp_frame_end,
   // Configuration channel.
   input  wire logic                            csr_valid,
   output logic                                 csr_ready,
   input  wire logic [wamf_pkg::CSR_IDX_W-1:0]  csr_index,
   input  wire logic [wamf_pkg::CFG_W-1:0]      csr_data
);

   logic                              push_valid;
   wamf_pkg::job_type                 push_job;
   logic                              pop;
   logic                              head_valid;
   wamf_pkg::job_type                 head_job;
   logic [wamf_pkg::LVL_W-1:0]        queue_level;

   // Configuration writes are taken at once.
   assign csr_ready = 1'b1;

   // Front: accepts requests and turns them into jobs.
   wamf_front #(
      .MAX_COLS (MAX_COLS),
      .MAX_ROWS (MAX_ROWS)
   ) u_front (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_sample  (req_sample),
      .req_stall   (req_stall),
      .csr_valid   (csr_valid && csr_ready),
      .csr_index   (csr_index),
      .csr_data    (csr_data),
      .queue_level (queue_level),
      .push_valid  (push_valid),
      .push_job    (push_job)
   );

   // Job queue between front and back.
   wamf_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_job   (push_job),
      .pop        (pop),
      .head_valid (head_valid),
      .head_job   (head_job),
      .level      (queue_level)
   );

   // Back: issues the results of each job.
   wamf_back u_back (
      .clock         (clock),
      .reset         (reset),
      .head_valid    (head_valid),
      .head_job      (head_job),
      .pop           (pop),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_out_row   (rsp_out_row),
      .rsp_out_col   (rsp_out_col),
      .rsp_value_q2  (rsp_value_q2),
      .rsp_run_last  (rsp_run_last),
      .rsp_frame_end (rsp_frame_end)
   );

endmodule

`default_nettype wire

### rtl/core/wamf_checker.sv
// Port-level checks of the 2x2 window filter, bound to its top level.
// Depends on wamf_pkg and window_2x2_avg_max_filter_unit_macros.svh.
`default_nettype none

`include "window_2x2_avg_max_filter_unit_macros.svh"

module wamf_checker (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            rsp_valid,
   input  wire logic                            rsp_stall,
   input  wire wamf_pkg::idx_type               rsp_out_row,
   input  wire wamf_pkg::idx_type               rsp_out_col,
   input  wire wamf_pkg::value_type             rsp_value_q2,
   input  wire logic                            rsp_run_last,
   input  wire logic                            rsp_frame_end
);

   localparam int PayW = 2 * wamf_pkg::IDX_W + wamf_pkg::VALUE_W + 2;

   // Whole response payload as one vector.
   logic [PayW-1:0] rsp_payload;

   assign rsp_payload = {rsp_out_row, rsp_out_col, rsp_value_q2, rsp_run_last, rsp_frame_end};

   // A stalled response stays offered.
   `WAMF_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall, rsp_valid, "stalled response dropped")

   // A stalled response keeps its payload.
   `WAMF_ASSERT_NEXT(a_rsp_stable, clock, reset, rsp_valid && rsp_stall, $stable(rsp_payload), "stalled response changed")

   // The frame-closing result is always the last one of its request.
   `WAMF_ASSERT_NOW(a_end_is_last, clock, reset, rsp_valid && rsp_frame_end, rsp_run_last, "frame end without run last")

   // Nothing is offered in the cycle after reset.
   `WAMF_ASSERT_NOW(a_reset_empty, clock, reset, $past(reset), !rsp_valid, "response right after reset")

endmodule

bind window_2x2_avg_max_filter_unit wamf_checker u_wamf_checker (.*);

`default_nettype wire
